@@ rtl/bbx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbx_pkg
// Shared constants, register indexes and types of the edge-normalized box blur.
// ----------------------------------------------------------------------------
package bbx_pkg;

   localparam int MAX_MASK  = 7;
   localparam int MAX_WIDTH = 1024;
   localparam int HALF_CAP  = MAX_MASK / 2;
   localparam int RING_ROWS = 2 * HALF_CAP + 2;

   localparam int PIX_W   = 24;
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;
   localparam int WID_W   = 11;                       // image_width field
   localparam int ROW_W   = 16;                       // image_height field
   localparam int MSK_W   = 3;                        // mask_size field
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int RING_W  = $clog2(RING_ROWS);
   localparam int ADDR_W  = $clog2(RING_ROWS * MAX_WIDTH);
   localparam int HALF_W  = $clog2(HALF_CAP + 1) > 0 ? $clog2(HALF_CAP + 1) : 1;
   localparam int SIDE    = 2 * HALF_CAP + 1;
   localparam int CNT_W   = $clog2(SIDE * SIDE + 1);
   localparam int SUM_W   = $clog2(SIDE * SIDE * 255 + 1);
   localparam int DIV_STEPS = CH_W;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_SIZE    = 2'd2;

   localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(640);
   localparam logic [ROW_W-1:0] RST_HEIGHT = ROW_W'(480);
   localparam logic [MSK_W-1:0] RST_MASK   = MSK_W'(3);

   // one slot of the divider chain: three channels share the count
   typedef struct packed {
      logic                          vld;
      logic                          last;
      logic [CNT_W-1:0]              dvs;
      logic [NUM_CH-1:0][CNT_W-1:0]  rem;
      logic [NUM_CH-1:0][CH_W-1:0]   quo;
   } div_stage_type;

endpackage
`default_nettype wire

@@ rtl/bbx_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbx_if
// Valid/ready channels of the blur: pixel request, result and register write.
// ----------------------------------------------------------------------------
interface bbx_req_if;
   import bbx_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] in_pixel;
   logic             drain;
   modport source (output valid, output in_pixel, output drain, input ready);
   modport sink   (input valid, input in_pixel, input drain, output ready);
endinterface

interface bbx_rsp_if;
   import bbx_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic             frame_end;
   modport source (output valid, output out_pixel, output frame_end, input ready);
   modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

interface bbx_csr_if;
   import bbx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/edge_normalized_box_blur_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_top
// Raster box blur with border renormalization over a ring of line stores.
// ----------------------------------------------------------------------------
// Flow: an item that releases a result sweeps its window through the single read
//   port of the line store, then waits until the division chain is empty and the
//   previous result is taken, since the chain and the output register carry one
//   pixel at a time; other items only check their window and return to idle.
// Result: the window sum runs through the division chain into the output register.
// Reset: 640 x 480 frame, mask 3, all position counters zero; line store uncleared.
module edge_normalized_box_blur_top (
   input  wire  clock,
   input  wire  reset,
   bbx_req_if.sink   req_chan,
   bbx_rsp_if.source rsp_chan,
   bbx_csr_if.sink   csr_chan
);
   import bbx_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [WID_W-1:0]   cfg_w_ff;
   logic [ROW_W-1:0]   cfg_h_ff;
   logic [MSK_W-1:0]   cfg_m_ff;
   logic [WID_W-1:0]   w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic [HALF_W-1:0]  half;
   logic [MSK_W-1:0]   half_raw;

   logic [COL_W-1:0]   in_col_ff, out_col_ff;
   logic [ROW_W-1:0]   in_row_ff, out_row_ff;
   logic [RING_W-1:0]  in_ring_ff, out_ring_ff;
   logic signed [HALF_W:0] dy_ff, dx_ff;

   logic [NUM_CH-1:0][SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PIX_W-1:0]   mem [RING_ROWS*MAX_WIDTH];
   logic [PIX_W-1:0]   rd_data_ff;
   logic               rd_vld_ff;

   logic               req_fire, csr_fire, wr_en, launch, last_px, win_ready, win_end;
   logic               inb;
   logic [ROW_W:0]     ry_raw;
   logic [ROW_W-1:0]   ry_c;
   logic [WID_W-1:0]   rx_raw, rx_c, in_col_x;
   logic signed [ROW_W+1:0] ny;
   logic signed [WID_W+1:0] nx;
   logic signed [RING_W+1:0] rs_raw;
   logic [RING_W-1:0]  rs;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic signed [HALF_W:0] half_s;

   div_stage_type      stage_head;
   div_stage_type      stage [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] chain_vld;
   logic               chain_busy;

   logic               rsp_vld_ff;
   logic [PIX_W-1:0]   rsp_pix_ff;
   logic               rsp_end_ff;

   // effective frame and window
   assign w_eff = (cfg_w_ff == '0) ? WID_W'(1) :
                  (cfg_w_ff > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : cfg_w_ff;
   assign h_eff = (cfg_h_ff == '0) ? ROW_W'(1) : cfg_h_ff;
   assign half_raw = cfg_m_ff >> 1;
   assign half = (half_raw > MSK_W'(HALF_CAP)) ? HALF_W'(HALF_CAP) : HALF_W'(half_raw);
   assign half_s = $signed({1'b0, half});

   assign req_fire = req_chan.valid & req_chan.ready;
   assign csr_fire = csr_chan.valid & csr_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign csr_chan.ready = !reset;
   assign wr_en = req_fire & ~req_chan.drain & (in_row_ff < h_eff);

   // readiness of the next output window
   assign ry_raw = {1'b0, out_row_ff} + (ROW_W+1)'(half);
   assign ry_c = (ry_raw > {1'b0, h_eff - ROW_W'(1)}) ? (h_eff - ROW_W'(1)) : ry_raw[ROW_W-1:0];
   assign rx_raw = WID_W'(out_col_ff) + WID_W'(half);
   assign rx_c = (rx_raw > (w_eff - WID_W'(1))) ? (w_eff - WID_W'(1)) : rx_raw;
   assign in_col_x = WID_W'(in_col_ff);
   assign win_ready = (ry_c < in_row_ff) || ((ry_c == in_row_ff) && (rx_c < in_col_x));

   // window sweep addressing
   assign ny = $signed({2'b00, out_row_ff}) + (ROW_W+2)'(dy_ff);
   assign nx = $signed({2'b00, WID_W'(out_col_ff)}) + (WID_W+2)'(dx_ff);
   assign inb = (ny >= 0) && (ny < $signed({2'b00, h_eff})) &&
                (nx >= 0) && (nx < $signed({2'b00, w_eff}));
   assign rs_raw = $signed({2'b00, out_ring_ff}) + (RING_W+2)'(dy_ff);
   always_comb begin
      if (rs_raw < 0) begin
         rs = RING_W'(rs_raw + (RING_W+2)'(RING_ROWS));
      end else if (rs_raw >= (RING_W+2)'(RING_ROWS)) begin
         rs = RING_W'(rs_raw - (RING_W+2)'(RING_ROWS));
      end else begin
         rs = RING_W'(rs_raw);
      end
   end
   assign rd_addr = ADDR_W'(rs) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx[COL_W-1:0]);
   assign wr_addr = ADDR_W'(in_ring_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
   assign win_end = (dy_ff == half_s) && (dx_ff == half_s);

   assign chain_busy = |chain_vld;
   assign launch = (state_ff == S_DIV) && !rsp_vld_ff && !chain_busy;
   assign last_px = (out_row_ff == h_eff - ROW_W'(1)) &&
                    (WID_W'(out_col_ff) == w_eff - WID_W'(1));

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_chan.in_pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_CHECK;
         S_CHECK: state_in = win_ready ? S_ACC : S_IDLE;
         S_ACC:   if (win_end) state_in = S_FLUSH;
         S_FLUSH: state_in = S_DIV;
         S_DIV:   if (launch) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cfg_w_ff    <= RST_WIDTH;
         cfg_h_ff    <= RST_HEIGHT;
         cfg_m_ff    <= RST_MASK;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == S_ACC) && inb;
         if (csr_fire && (csr_chan.index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                                 REG_MASK_SIZE})) begin
            case (csr_chan.index)
               REG_IMAGE_WIDTH:  cfg_w_ff <= csr_chan.data[WID_W-1:0];
               REG_IMAGE_HEIGHT: cfg_h_ff <= csr_chan.data[ROW_W-1:0];
               REG_MASK_SIZE:    cfg_m_ff <= csr_chan.data[MSK_W-1:0];
               default:          cfg_m_ff <= cfg_m_ff;
            endcase
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_ring_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_ring_ff <= '0;
         end else if (launch && last_px) begin
            // frame done: next pixel opens a new frame
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_ring_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_ring_ff <= '0;
         end else begin
            if (wr_en) begin
               if (WID_W'(in_col_ff) + WID_W'(1) >= w_eff) begin
                  in_col_ff  <= '0;
                  in_row_ff  <= in_row_ff + ROW_W'(1);
                  in_ring_ff <= (in_ring_ff == RING_W'(RING_ROWS - 1)) ? '0 :
                                in_ring_ff + RING_W'(1);
               end else begin
                  in_col_ff <= in_col_ff + COL_W'(1);
               end
            end
            if (launch) begin
               if (WID_W'(out_col_ff) + WID_W'(1) >= w_eff) begin
                  out_col_ff  <= '0;
                  out_row_ff  <= out_row_ff + ROW_W'(1);
                  out_ring_ff <= (out_ring_ff == RING_W'(RING_ROWS - 1)) ? '0 :
                                 out_ring_ff + RING_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   // window offsets and channel sums
   always_ff @(posedge clock) begin
      if (state_ff == S_CHECK) begin
         dy_ff  <= -half_s;
         dx_ff  <= -half_s;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (state_ff == S_ACC) begin
            if (dx_ff == half_s) begin
               dx_ff <= -half_s;
               dy_ff <= dy_ff + (HALF_W+1)'(1);
            end else begin
               dx_ff <= dx_ff + (HALF_W+1)'(1);
            end
         end
         if (rd_vld_ff) begin
            for (int c = 0; c < NUM_CH; c++) begin
               sum_ff[c] <= sum_ff[c] + SUM_W'(rd_data_ff[c*CH_W +: CH_W]);
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // division chain: upper sum bits are already below the count
   always_comb begin
      stage_head.vld  = launch;
      stage_head.last = last_px;
      stage_head.dvs  = cnt_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         stage_head.rem[c] = CNT_W'(sum_ff[c][SUM_W-1:CH_W]);
         stage_head.quo[c] = sum_ff[c][CH_W-1:0];
      end
   end

   assign stage[0] = stage_head;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      bbx_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
      assign chain_vld[i] = stage[i+1].vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (stage[DIV_STEPS].vld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage[DIV_STEPS].vld) begin
         rsp_pix_ff <= stage[DIV_STEPS].quo;
         rsp_end_ff <= stage[DIV_STEPS].last;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.out_pixel = rsp_pix_ff;
   assign rsp_chan.frame_end = rsp_end_ff;

   a_chain_into_empty: assert property (@(posedge clock) disable iff (reset)
      stage[DIV_STEPS].vld |-> !rsp_vld_ff)
      else $error("division result would overwrite a pending transfer");

   a_one_in_chain: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld))
      else $error("more than one pixel in the division chain");

   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      WID_W'(in_col_ff) < w_eff)
      else $error("input column beyond frame width");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      WID_W'(out_col_ff) < w_eff)
      else $error("output column beyond frame width");

endmodule
`default_nettype wire

@@ rtl/bbx_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbx_div_cell
// One restoring-division step for three channels; hands its slot on each cycle.
// ----------------------------------------------------------------------------
module bbx_div_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  bbx_pkg::div_stage_type stage_in,
   output bbx_pkg::div_stage_type stage_out
);
   import bbx_pkg::*;

   div_stage_type stage_in_w;
   div_stage_type stage_ff;

   always_comb begin
      logic [CNT_W:0] sh;
      logic [CNT_W:0] dv;
      stage_in_w = stage_in;
      dv = {1'b0, stage_in.dvs};
      for (int c = 0; c < NUM_CH; c++) begin
         sh = {stage_in.rem[c], stage_in.quo[c][CH_W-1]};
         if (sh >= dv) begin
            stage_in_w.rem[c] = CNT_W'(sh - dv);
            stage_in_w.quo[c] = {stage_in.quo[c][CH_W-2:0], 1'b1};
         end else begin
            stage_in_w.rem[c] = sh[CNT_W-1:0];
            stage_in_w.quo[c] = {stage_in.quo[c][CH_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire
